### hdl/ansi_sgr_colour_parser_macros.svh
// Assertion macros used by the port-level checker (ascp_checker.sv).
`ifndef ANSI_SGR_COLOUR_PARSER_MACROS_SVH
`define ANSI_SGR_COLOUR_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ascp_pkg.sv
// Types and constants of the ANSI SGR colour parser.
package ascp_pkg;

  localparam logic [7:0] ESC_BYTE     = 8'd27;
  localparam logic [7:0] BRACKET_BYTE = 8'h5B;
  localparam logic [7:0] FINAL_BYTE   = 8'h6D;
  localparam logic [7:0] SEP_BYTE     = 8'h3B;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] DIGIT_NINE   = 8'h39;

  localparam logic [3:0] DEFAULT_COLOUR = 4'd9;

  localparam int unsigned  TOKEN_W   = 10;
  localparam logic [9:0]   VALUE_MAX = 10'd1023;

  // SGR parameter codes
  localparam logic [9:0] SGR_RESET  = 10'd0;
  localparam logic [9:0] FG_BASE    = 10'd30;
  localparam logic [9:0] FG_LAST    = 10'd37;
  localparam logic [9:0] FG_DEFAULT = 10'd39;
  localparam logic [9:0] BG_BASE    = 10'd40;
  localparam logic [9:0] BG_LAST    = 10'd47;
  localparam logic [9:0] BG_DEFAULT = 10'd49;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_PARAMS = 2'd2
  } ascp_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_end;
  } ascp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] fg_index;
    logic [3:0] bg_index;
    logic       run_last;
  } ascp_out_t;

  // Results caused by one request: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    ascp_out_t  first;
    ascp_out_t  second;
  } ascp_pair_t;

endpackage

### hdl/ascp_parser.sv
// Escape-sequence parser: parse state, colour state and result building.
module ascp_parser import ascp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ascp_in_t   item,
  input  logic       advance,
  output ascp_pair_t pair
);

  ascp_mode_t         mode_r, mode_nxt;
  logic [3:0]         cur_fg_r, cur_fg_nxt;
  logic [3:0]         cur_bg_r, cur_bg_nxt;
  logic [3:0]         pend_fg_r, pend_fg_nxt;
  logic [3:0]         pend_bg_r, pend_bg_nxt;
  logic [TOKEN_W-1:0] tok_val_r, tok_val_nxt;
  logic               tok_seen_r, tok_seen_nxt;
  logic               tok_bad_r, tok_bad_nxt;
  logic               abort_r, abort_nxt;
  logic               params_r, params_nxt;

  // token close-out
  logic [3:0]         fin_fg, fin_bg;
  logic               fin_abort;
  logic [TOKEN_W-1:0] fg_diff, bg_diff;

  // decimal accumulate: value * 10 + digit
  logic [13:0]        acc;
  logic [TOKEN_W-1:0] acc_sat;
  logic               is_digit;

  assign fg_diff  = tok_val_r - FG_BASE;
  assign bg_diff  = tok_val_r - BG_BASE;
  assign acc      = {1'b0, tok_val_r, 3'b000} + {3'b000, tok_val_r, 1'b0}
                  + {10'd0, item.in_byte[3:0]};
  assign acc_sat  = (acc > {4'd0, VALUE_MAX}) ? VALUE_MAX : acc[TOKEN_W-1:0];
  assign is_digit = (item.in_byte >= DIGIT_ZERO) && (item.in_byte <= DIGIT_NINE);

  always_comb begin
    fin_fg    = pend_fg_r;
    fin_bg    = pend_bg_r;
    fin_abort = abort_r;
    if (tok_seen_r) begin
      if (tok_bad_r) begin
        fin_abort = 1'b1;
      end else if (tok_val_r == SGR_RESET) begin
        fin_fg = DEFAULT_COLOUR;
        fin_bg = DEFAULT_COLOUR;
      end else if (((tok_val_r >= FG_BASE) && (tok_val_r <= FG_LAST)) ||
                   (tok_val_r == FG_DEFAULT)) begin
        fin_fg = fg_diff[3:0];
      end else if (((tok_val_r >= BG_BASE) && (tok_val_r <= BG_LAST)) ||
                   (tok_val_r == BG_DEFAULT)) begin
        fin_bg = bg_diff[3:0];
      end
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    cur_fg_nxt   = cur_fg_r;
    cur_bg_nxt   = cur_bg_r;
    pend_fg_nxt  = pend_fg_r;
    pend_bg_nxt  = pend_bg_r;
    tok_val_nxt  = tok_val_r;
    tok_seen_nxt = tok_seen_r;
    tok_bad_nxt  = tok_bad_r;
    abort_nxt    = abort_r;
    params_nxt   = params_r;
    pair         = '0;

    case (mode_r)
      MODE_ESCAPE: begin
        if (item.in_byte == BRACKET_BYTE) begin
          mode_nxt     = MODE_PARAMS;
          pend_fg_nxt  = DEFAULT_COLOUR;
          pend_bg_nxt  = DEFAULT_COLOUR;
          tok_val_nxt  = '0;
          tok_seen_nxt = 1'b0;
          tok_bad_nxt  = 1'b0;
          abort_nxt    = 1'b0;
          params_nxt   = 1'b0;
        end else begin
          pair.count  = 2'd2;
          pair.first  = '{out_byte: ESC_BYTE, fg_index: cur_fg_r,
                          bg_index: cur_bg_r, run_last: 1'b0};
          pair.second = '{out_byte: item.in_byte, fg_index: cur_fg_r,
                          bg_index: cur_bg_r, run_last: 1'b1};
          mode_nxt    = MODE_NORMAL;
        end
      end
      MODE_PARAMS: begin
        if (item.in_byte == FINAL_BYTE) begin
          pend_fg_nxt  = fin_fg;
          pend_bg_nxt  = fin_bg;
          abort_nxt    = fin_abort;
          tok_val_nxt  = '0;
          tok_seen_nxt = 1'b0;
          tok_bad_nxt  = 1'b0;
          if (params_r) begin
            cur_fg_nxt = fin_abort ? DEFAULT_COLOUR : fin_fg;
            cur_bg_nxt = fin_abort ? DEFAULT_COLOUR : fin_bg;
          end
          mode_nxt = MODE_NORMAL;
        end else begin
          params_nxt = 1'b1;
          if (item.in_byte == SEP_BYTE) begin
            pend_fg_nxt  = fin_fg;
            pend_bg_nxt  = fin_bg;
            abort_nxt    = fin_abort;
            tok_val_nxt  = '0;
            tok_seen_nxt = 1'b0;
            tok_bad_nxt  = 1'b0;
          end else if (is_digit) begin
            tok_val_nxt  = acc_sat;
            tok_seen_nxt = 1'b1;
          end else begin
            tok_bad_nxt  = 1'b1;
            tok_seen_nxt = 1'b1;
          end
        end
      end
      default: begin
        // normal text; the unused mode code behaves the same
        if (item.in_byte == ESC_BYTE) begin
          mode_nxt = MODE_ESCAPE;
        end else begin
          pair.count = 2'd1;
          pair.first = '{out_byte: item.in_byte, fg_index: cur_fg_r,
                         bg_index: cur_bg_r, run_last: 1'b1};
          mode_nxt   = MODE_NORMAL;
        end
      end
    endcase

    if (item.chunk_end) begin
      mode_nxt     = MODE_NORMAL;
      cur_fg_nxt   = DEFAULT_COLOUR;
      cur_bg_nxt   = DEFAULT_COLOUR;
      pend_fg_nxt  = DEFAULT_COLOUR;
      pend_bg_nxt  = DEFAULT_COLOUR;
      tok_val_nxt  = '0;
      tok_seen_nxt = 1'b0;
      tok_bad_nxt  = 1'b0;
      abort_nxt    = 1'b0;
      params_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NORMAL;
      cur_fg_r   <= DEFAULT_COLOUR;
      cur_bg_r   <= DEFAULT_COLOUR;
      pend_fg_r  <= DEFAULT_COLOUR;
      pend_bg_r  <= DEFAULT_COLOUR;
      tok_val_r  <= '0;
      tok_seen_r <= 1'b0;
      tok_bad_r  <= 1'b0;
      abort_r    <= 1'b0;
      params_r   <= 1'b0;
    end else if (advance) begin
      mode_r     <= mode_nxt;
      cur_fg_r   <= cur_fg_nxt;
      cur_bg_r   <= cur_bg_nxt;
      pend_fg_r  <= pend_fg_nxt;
      pend_bg_r  <= pend_bg_nxt;
      tok_val_r  <= tok_val_nxt;
      tok_seen_r <= tok_seen_nxt;
      tok_bad_r  <= tok_bad_nxt;
      abort_r    <= abort_nxt;
      params_r   <= params_nxt;
    end
  end

endmodule

### hdl/ascp_out_buf.sv
// Result register: holds up to two results and hands them out one at a time.
module ascp_out_buf import ascp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ascp_pair_t pair,
  input  logic       load_req,
  output logic       load_ok,
  output logic       out_valid,
  input  logic       out_stall,
  output ascp_out_t  out_data
);

  logic [1:0] cnt_r, cnt_nxt;
  ascp_out_t  res0_r, res0_nxt;
  ascp_out_t  res1_r, res1_nxt;
  logic       pop;
  logic       load;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = res0_r;
  assign pop       = out_valid && !out_stall;
  assign load_ok   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign load      = load_req && load_ok && (pair.count != 2'd0);

  always_comb begin
    cnt_nxt  = cnt_r;
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    if (load) begin
      cnt_nxt  = pair.count;
      res0_nxt = pair.first;
      res1_nxt = pair.second;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      if (cnt_r == 2'd2) begin
        res0_nxt = res1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

endmodule

### hdl/ansi_sgr_colour_parser.sv
// Top level of the ANSI SGR colour parser: input register, parser, result register.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   in_      | in_valid / in_stall    | in_data  : in_byte, chunk_end
//   out_     | out_valid / out_stall  | out_data : out_byte, fg/bg_index, run_last
//
// One byte request is taken per cycle while in_stall is low. A taken byte is held in
// the input register and parsed from there into the result register, which offers the
// first result. ESC followed by a byte other than '[' gives two results; the result
// register hands out one per cycle while out_stall is low, so a following byte that
// gives results waits in the input register until the result register can take it.
// Bytes that give no result (escape and parameter bytes) pass even while the
// result register is full. Reset (rst_n low, synchronous) empties both
// registers and sets both colours to default.
module ansi_sgr_colour_parser import ascp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ascp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ascp_out_t out_data
);

  logic       in_vld_r, in_vld_nxt;
  ascp_in_t   in_item_r, in_item_nxt;
  ascp_pair_t pair;
  logic       load_ok;
  logic       advance;

  // A parsed byte moves on when its results fit, or when it has none.
  assign advance  = in_vld_r && (load_ok || (pair.count == 2'd0));
  assign in_stall = in_vld_r && !advance;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_item_nxt = in_item_r;
    if (!in_stall) begin
      in_vld_nxt = in_valid;
      if (in_valid) begin
        in_item_nxt = in_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
  end

  // Parse state only moves when the registered byte is consumed.
  ascp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (in_item_r),
    .advance (advance),
    .pair    (pair)
  );

  ascp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .pair      (pair),
    .load_req  (in_vld_r),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hdl/ascp_checker.sv
// Port-level checks for the ANSI SGR colour parser, bound to the top level.
`include "ansi_sgr_colour_parser_macros.svh"

module ascp_checker import ascp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input ascp_out_t out_data
);

  `ASCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `ASCP_ASSERT_NOW(a_fg_range, out_valid, (out_data.fg_index <= 4'd7) || (out_data.fg_index == DEFAULT_COLOUR), "foreground index out of range")
  `ASCP_ASSERT_NOW(a_bg_range, out_valid, (out_data.bg_index <= 4'd7) || (out_data.bg_index == DEFAULT_COLOUR), "background index out of range")
  `ASCP_ASSERT_NOW(a_esc_first, out_valid && !out_data.run_last, out_data.out_byte == ESC_BYTE, "non-final result is not ESC")

endmodule

bind ansi_sgr_colour_parser ascp_checker u_ascp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### sim/ansi_sgr_colour_parser_chk.sv
// Checker for the ANSI SGR colour parser: follows the byte stream, predicts colours, compares results.
`timescale 1ns / 100ps
module ansi_sgr_colour_parser_chk import ascp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  ascp_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  ascp_out_t out_data,
  output int        fail_count,
  output int        waiting,
  output int        compared
);

  ascp_mode_t mode;
  logic [3:0] cur_fg, cur_bg, pend_fg, pend_bg;
  logic [9:0] tok_val;
  logic       tok_seen, tok_bad, seq_bad, any_param;
  ascp_out_t  expected_glyphs[$];
  int         errors = 0;
  int         matched = 0;

  function void clear_parser();
    mode = MODE_NORMAL;
    cur_fg = DEFAULT_COLOUR;
    cur_bg = DEFAULT_COLOUR;
    pend_fg = DEFAULT_COLOUR;
    pend_bg = DEFAULT_COLOUR;
    tok_val = '0;
    tok_seen = 1'b0;
    tok_bad = 1'b0;
    seq_bad = 1'b0;
    any_param = 1'b0;
  endfunction

  // Apply the open parameter to the pending colours, then start a new one.
  function void close_param();
    logic [9:0] off;
    if (tok_seen && tok_bad) begin
      seq_bad = 1'b1;
    end else if (tok_seen) begin
      if (tok_val == SGR_RESET) begin
        pend_fg = DEFAULT_COLOUR;
        pend_bg = DEFAULT_COLOUR;
      end else if ((tok_val >= FG_BASE && tok_val <= FG_LAST) || tok_val == FG_DEFAULT) begin
        off = tok_val - FG_BASE;
        pend_fg = off[3:0];
      end else if ((tok_val >= BG_BASE && tok_val <= BG_LAST) || tok_val == BG_DEFAULT) begin
        off = tok_val - BG_BASE;
        pend_bg = off[3:0];
      end
    end
    tok_val = '0;
    tok_seen = 1'b0;
    tok_bad = 1'b0;
  endfunction

  function void emit_glyph(input logic [7:0] b, input logic last);
    ascp_out_t g;
    g.out_byte = b;
    g.fg_index = cur_fg;
    g.bg_index = cur_bg;
    g.run_last = last;
    expected_glyphs = {expected_glyphs, g};
  endfunction

  function void parse_byte(input ascp_in_t req);
    logic [7:0] b;
    int         acc;
    b = req.in_byte;
    case (mode)
      MODE_ESCAPE: begin
        if (b == BRACKET_BYTE) begin
          mode = MODE_PARAMS;
          pend_fg = DEFAULT_COLOUR;
          pend_bg = DEFAULT_COLOUR;
          tok_val = '0;
          tok_seen = 1'b0;
          tok_bad = 1'b0;
          seq_bad = 1'b0;
          any_param = 1'b0;
        end else begin
          emit_glyph(ESC_BYTE, 1'b0);
          emit_glyph(b, 1'b1);
          mode = MODE_NORMAL;
        end
      end
      MODE_PARAMS: begin
        if (b == FINAL_BYTE) begin
          close_param();
          // empty sequence leaves the colours alone
          if (any_param && seq_bad) begin
            cur_fg = DEFAULT_COLOUR;
            cur_bg = DEFAULT_COLOUR;
          end else if (any_param) begin
            cur_fg = pend_fg;
            cur_bg = pend_bg;
          end
          mode = MODE_NORMAL;
        end else begin
          any_param = 1'b1;
          if (b == SEP_BYTE) begin
            close_param();
          end else if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
            acc = int'(tok_val) * 10 + int'(b - DIGIT_ZERO);
            tok_val = (acc > int'(VALUE_MAX)) ? VALUE_MAX : acc[9:0];
            tok_seen = 1'b1;
          end else begin
            tok_bad = 1'b1;
            tok_seen = 1'b1;
          end
        end
      end
      default: begin
        if (b == ESC_BYTE) begin
          mode = MODE_ESCAPE;
        end else begin
          emit_glyph(b, 1'b1);
          mode = MODE_NORMAL;
        end
      end
    endcase
    if (req.chunk_end) clear_parser();
  endfunction

  always @(posedge clk) begin : watch
    ascp_out_t want;
    if (!rst_n) begin
      clear_parser();
      expected_glyphs.delete();
    end else begin
      // predict first: new expectations go to the back, the oldest stays in front
      if (in_valid && !in_stall) parse_byte(in_data);
      if (out_valid && !out_stall) begin
        if (expected_glyphs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: byte %02h fg %0d bg %0d last %0d", $time,
                   out_data.out_byte, out_data.fg_index, out_data.bg_index, out_data.run_last);
        end else begin
          want = expected_glyphs.pop_front();
          matched++;
          if (out_data.out_byte !== want.out_byte || out_data.fg_index !== want.fg_index ||
              out_data.bg_index !== want.bg_index || out_data.run_last !== want.run_last) begin
            errors++;
            $display("%0t: mismatch: expected byte %02h fg %0d bg %0d last %0d", $time,
                     want.out_byte, want.fg_index, want.bg_index, want.run_last);
            $display("%0t:           actual   byte %02h fg %0d bg %0d last %0d", $time,
                     out_data.out_byte, out_data.fg_index, out_data.bg_index,
                     out_data.run_last);
          end
        end
      end
    end
    fail_count <= errors;
    waiting <= expected_glyphs.size();
    compared <= matched;
  end

endmodule

### sim/ansi_sgr_colour_parser_tb.sv
// Testbench top for the ANSI SGR colour parser: byte stimulus, result sink, watchdog and verdict.
`timescale 1ns / 100ps
module ansi_sgr_colour_parser_tb;
  import ascp_pkg::*;

  localparam int RANDOM_BYTES = 400;  // size of the random part
  localparam int HOLD_CYCLES  = 300;  // one long output hold-off, fills the pipe
  localparam int QUIET_LIMIT  = 3000; // cycles with no request or result moving
  localparam int DRAIN_CYCLES = 8;    // settle time after the checker has no results left waiting

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ascp_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ascp_out_t out_data;

  int fail_count;
  int waiting;
  int compared;

  // Pacing knobs. A calm side never idles; the stimulus flips these now and
  // then so the run has both gap-free stretches and ragged ones.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_req = 1'b0;
  bit ends_noise = 1'b0; // sprinkle chunk ends on random bytes

  int n_bytes = 0;
  int n_sgr = 0;
  int n_ends = 0;
  int quiet = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ansi_sgr_colour_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ansi_sgr_colour_parser_chk colour_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .waiting    (waiting),
    .compared   (compared)
  );

  // Idle cycles before the next request or the next take.
  // Mostly zero so the block also sees back-to-back traffic.
  function automatic int idle_cycles(input bit calm);
    if (calm || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Offer one byte request and hold it until taken. valid only drops when a
  // gap is drawn, so it is never lowered and raised in the same step.
  task automatic put_byte(input logic [7:0] b, input logic e);
    ascp_in_t req;
    int       gap;
    gap = idle_cycles(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.in_byte = b;
    req.chunk_end = e | (ends_noise && $urandom_range(0, 39) == 0);
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_bytes++;
    if (req.chunk_end) n_ends++;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
  endtask

  // ESC '[' params 'm'
  task automatic put_sgr(input string params);
    put_byte(ESC_BYTE, 1'b0);
    put_byte(BRACKET_BYTE, 1'b0);
    put_str(params);
    put_byte(FINAL_BYTE, 1'b0);
    n_sgr++;
  endtask

  // Result sink: random stalls per result, plus one long hold-off on request
  // from the stimulus so the block backs up and stalls its input.
  initial begin : result_sink
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = idle_cycles(rx_calm);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: timeout, nothing moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int         kind;
    int         ntok;
    int         stop;
    bit         hold_done;
    string      p;
    string      tok;
    logic [7:0] ch;

    hold_done = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    put_byte(8'h00, 1'b0);       // lowest byte, reset colours 9/9
    put_sgr("31;44");            // fg 1, bg 4
    put_byte(8'hFF, 1'b0);       // highest byte, shows 1/4
    put_sgr("");                 // empty sequence: colours unchanged
    put_byte(ESC_BYTE, 1'b0);    // ESC ESC: two results, both ESC, still 1/4
    put_byte(ESC_BYTE, 1'b0);
    put_sgr("+");                // sign makes the token bad: defaults for the sequence
    put_byte(ESC_BYTE, 1'b0);    // ESC + other byte: two results at 9/9
    put_byte("x", 1'b0);
    put_sgr("45;1054");          // 1054 saturates and is ignored (a wrap would give fg 0)
    put_byte("C", 1'b1);         // shows 9/5, then the chunk end clears everything

    // ---- random part ----
    // Mostly well-formed SGR sequences and text runs with random content;
    // the rest is stray ESC pairs, raw noise and sequences cut off by a chunk end.
    ends_noise = 1'b1;
    stop = n_bytes + RANDOM_BYTES;
    while (n_bytes < stop) begin
      if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 9) == 0) rx_calm = !rx_calm;
      // halfway through: long output hold-off while the sender keeps pushing
      if (!hold_done && n_bytes >= stop - RANDOM_BYTES / 2) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
        tx_calm = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // run of random bytes, anything but ESC
        repeat ($urandom_range(1, 6)) begin
          do ch = 8'($urandom_range(0, 255)); while (ch == ESC_BYTE);
          put_byte(ch, 1'b0);
        end
      end else if (kind < 72) begin
        p = "";
        ntok = $urandom_range(0, 3);
        for (int t = 0; t < ntok; t++) begin
          case ($urandom_range(0, 9))
            0, 1, 2: tok = $sformatf("%0d", $urandom_range(30, 39));
            3, 4:    tok = $sformatf("%0d", $urandom_range(40, 49));
            5: begin
              if ($urandom_range(0, 1) != 0) tok = "0";
              else tok = "00";
            end
            6:       tok = $sformatf("%0d", $urandom_range(0, 999));
            // big values whose low 10 bits land near the colour codes
            7:       tok = $sformatf("%0d", 1024 * $urandom_range(1, 60) + $urandom_range(28, 50));
            8:       tok = "";
            default: tok = $sformatf("%0d", $urandom_range(0, 99));
          endcase
          // now and then spoil the token with a non-digit
          if ($urandom_range(0, 11) == 0) begin
            do ch = 8'($urandom_range(0, 255));
            while ((ch >= DIGIT_ZERO && ch <= DIGIT_NINE) || ch == SEP_BYTE || ch == FINAL_BYTE);
            tok = ($urandom_range(0, 1) != 0) ? $sformatf("%c%s", ch, tok)
                                              : $sformatf("%s%c", tok, ch);
          end
          p = (t == 0) ? tok : {p, ";", tok};
        end
        put_sgr(p);
      end else if (kind < 82) begin
        // ESC followed by anything but '[' (ESC included)
        put_byte(ESC_BYTE, 1'b0);
        do ch = 8'($urandom_range(0, 255)); while (ch == BRACKET_BYTE);
        put_byte(ch, 1'b0);
      end else if (kind < 94) begin
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        // unterminated sequence, dropped by a chunk end
        put_byte(ESC_BYTE, 1'b0);
        put_byte(BRACKET_BYTE, 1'b0);
        put_str($sformatf("%0d;", $urandom_range(30, 47)));
        put_byte(DIGIT_ZERO + 8'($urandom_range(0, 9)), 1'b1);
      end
    end
    in_valid <= 1'b0;

    // checker outputs are registered; let the last request register first
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d byte requests: %0d SGR sequences, %0d chunk ends, one %0d-cycle hold-off.",
             n_bytes, n_sgr, n_ends, HOLD_CYCLES);
    $display("Compared %0d results against the predicted colours.", compared);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
